### rtl/bctd_pkg.sv
package bctd_pkg;

  localparam logic [2:0] FMT_BC1 = 3'd0;
  localparam logic [2:0] FMT_BC2 = 3'd1;
  localparam logic [2:0] FMT_BC3 = 3'd2;
  localparam logic [2:0] FMT_BC4 = 3'd3;
  localparam logic [2:0] FMT_BC5 = 3'd4;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [2:0]       fmt;
    logic [3:0][31:0] pal;
    logic [31:0]      cidx;
    logic [7:0][7:0]  tab_a;
    logic [7:0][7:0]  tab_b;
    logic [47:0]      aidx;
    logic [47:0]      bidx;
    logic [63:0]      alo;
  } blk_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       bc5;
    logic [3:0] idx;
    logic       last;
  } txl_t;

endpackage

### rtl/bctd_front.sv
module bctd_front #(
  parameter int Depth = bctd_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [2:0]        fmt,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [63:0]       lo,
  input  logic [63:0]       hi,
  output logic              q_valid,
  output bctd_pkg::blk_t    q_head,
  input  logic              pop
);

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return p[18:11];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd3277;
    return p[21:14];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd2341;
    return p[21:14];
  endfunction

  function automatic logic [7:0][7:0] chan_tab(input logic [15:0] h);
    logic [7:0][7:0] t;
    logic [7:0] a0, a1;
    a0 = h[7:0];
    a1 = h[15:8];
    t = '0;
    t[0] = a0;
    t[1] = a1;
    if (a0 > a1) begin
      for (int i = 1; i <= 6; i++) begin
        t[i+1] = div7(11'(a0) * 11'(7 - i) + 11'(a1) * 11'(i));
      end
    end else begin
      for (int i = 1; i <= 4; i++) begin
        t[i+1] = div5(11'(a0) * 11'(5 - i) + 11'(a1) * 11'(i));
      end
      t[6] = 8'd0;
      t[7] = 8'd255;
    end
    return t;
  endfunction

  bctd_pkg::blk_t q_r [Depth];
  logic [PW-1:0]  wp_r, rp_r;
  logic [CW-1:0]  cnt_r;
  bctd_pkg::blk_t ent;
  logic           push;
  logic [63:0]    ch;
  logic [15:0]    c0, c1;
  logic           four;
  logic [2:0][7:0] e0, e1;

  assign in_stall = (cnt_r == CW'(Depth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_head   = q_r[rp_r];

  always_comb begin
    ch = (fmt == bctd_pkg::FMT_BC2 || fmt == bctd_pkg::FMT_BC3) ? hi : lo;
    c0 = ch[15:0];
    c1 = ch[31:16];
    four = (c0 > c1) || fmt == bctd_pkg::FMT_BC2 || fmt == bctd_pkg::FMT_BC3;
    e0[0] = {c0[15:11], c0[15:13]};
    e0[1] = {c0[10:5], c0[10:9]};
    e0[2] = {c0[4:0], c0[4:2]};
    e1[0] = {c1[15:11], c1[15:13]};
    e1[1] = {c1[10:5], c1[10:9]};
    e1[2] = {c1[4:0], c1[4:2]};
    ent.fmt = fmt;
    for (int c = 0; c < 3; c++) begin
      ent.pal[0][31-8*c -: 8] = e0[c];
      ent.pal[1][31-8*c -: 8] = e1[c];
      if (four) begin
        ent.pal[2][31-8*c -: 8] = div3({e0[c], 1'b0} + 10'(e1[c]));
        ent.pal[3][31-8*c -: 8] = div3(10'(e0[c]) + {e1[c], 1'b0});
      end else begin
        ent.pal[2][31-8*c -: 8] = 8'((10'(e0[c]) + 10'(e1[c])) >> 1);
        ent.pal[3][31-8*c -: 8] = 8'd0;
      end
    end
    ent.pal[0][7:0] = 8'd255;
    ent.pal[1][7:0] = 8'd255;
    ent.pal[2][7:0] = 8'd255;
    ent.pal[3][7:0] = four ? 8'd255 : 8'd0;
    ent.cidx  = ch[63:32];
    ent.tab_a = chan_tab(lo[15:0]);
    ent.tab_b = chan_tab(hi[15:0]);
    ent.aidx  = lo[63:16];
    ent.bidx  = hi[63:16];
    ent.alo   = lo;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(Depth - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(Depth - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(Depth)) else $error("queue count overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0) else $error("pop from empty queue");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1) else $error("push not counted");

endmodule

### rtl/bctd_back.sv
module bctd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           q_valid,
  input  bctd_pkg::blk_t q_head,
  output logic           pop,
  output logic           t_valid,
  output bctd_pkg::txl_t t_txl
);

  logic [3:0]     cnt_r;
  logic           t_valid_r;
  bctd_pkg::txl_t t_r, t_nxt;
  logic [1:0]     ci;
  logic [2:0]     ai, bi;
  logic [3:0]     nib;
  logic [31:0]    pe;

  assign pop     = en && q_valid && (cnt_r == 4'hF);
  assign t_valid = t_valid_r;
  assign t_txl   = t_r;

  always_comb begin
    ci  = q_head.cidx[2*cnt_r +: 2];
    ai  = q_head.aidx[3*cnt_r +: 3];
    bi  = q_head.bidx[3*cnt_r +: 3];
    nib = q_head.alo[4*cnt_r +: 4];
    pe  = q_head.pal[ci];
    t_nxt.r    = pe[31:24];
    t_nxt.g    = pe[23:16];
    t_nxt.b    = pe[15:8];
    t_nxt.a    = pe[7:0];
    t_nxt.bc5  = 1'b0;
    t_nxt.idx  = cnt_r;
    t_nxt.last = (cnt_r == 4'hF);
    case (q_head.fmt)
      bctd_pkg::FMT_BC2: begin
        t_nxt.a = {nib, nib};
      end
      bctd_pkg::FMT_BC3: begin
        t_nxt.a = q_head.tab_a[ai];
      end
      bctd_pkg::FMT_BC4: begin
        t_nxt.r = q_head.tab_a[ai];
        t_nxt.g = q_head.tab_a[ai];
        t_nxt.b = q_head.tab_a[ai];
        t_nxt.a = 8'd255;
      end
      bctd_pkg::FMT_BC5: begin
        t_nxt.r   = q_head.tab_a[ai];
        t_nxt.g   = q_head.tab_b[bi];
        t_nxt.a   = 8'd255;
        t_nxt.bc5 = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      t_valid_r <= 1'b0;
    end else if (en) begin
      t_valid_r <= q_valid;
      if (q_valid) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= t_nxt;
    end
  end

endmodule

### rtl/bctd_root.sv
module bctd_root (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           t_valid,
  input  bctd_pkg::txl_t t_txl,
  output logic           o_valid,
  output bctd_pkg::txl_t o_txl
);

  localparam int Steps = 8;

  typedef struct packed {
    bctd_pkg::txl_t t;
    logic [15:0]    x;
    logic [15:0]    q;
  } rst_t;

  logic  v_r   [Steps+1];
  rst_t  s_r   [Steps+1];
  rst_t  s_nxt [Steps+1];
  logic  o_valid_r;
  bctd_pkg::txl_t o_r, o_nxt;
  logic signed [18:0] dx, dy;
  logic signed [18:0] sq;
  logic [15:0]        stp;

  always_comb begin
    dx = $signed({10'd0, t_txl.r, 1'b0}) - 19'sd255;
    dy = $signed({10'd0, t_txl.g, 1'b0}) - 19'sd255;
    sq = 19'sd65025 - dx * dx - dy * dy;
    s_nxt[0].t = t_txl;
    s_nxt[0].x = sq[18] ? 16'd0 : sq[15:0];
    s_nxt[0].q = 16'd0;
    stp = 16'd0;
    for (int k = 0; k < Steps; k++) begin
      stp = 16'(1) << (14 - 2 * k);
      s_nxt[k+1] = s_r[k];
      if (s_r[k].x >= s_r[k].q + stp) begin
        s_nxt[k+1].x = s_r[k].x - (s_r[k].q + stp);
        s_nxt[k+1].q = (s_r[k].q >> 1) + stp;
      end else begin
        s_nxt[k+1].q = s_r[k].q >> 1;
      end
    end
  end

  always_comb begin
    o_nxt = s_r[Steps].t;
    if (s_r[Steps].t.bc5) begin
      o_nxt.b = 8'((s_r[Steps].q + 16'd255) >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= Steps; k++) begin
        v_r[k] <= 1'b0;
      end
      o_valid_r <= 1'b0;
    end else if (en) begin
      v_r[0] <= t_valid;
      for (int k = 0; k < Steps; k++) begin
        v_r[k+1] <= v_r[k];
      end
      o_valid_r <= v_r[Steps];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= Steps; k++) begin
        s_r[k] <= (k == 0) ? s_nxt[0] : s_nxt[k];
      end
      o_r <= o_nxt;
    end
  end

  assign o_valid = o_valid_r;
  assign o_txl   = o_r;

endmodule

### rtl/bc_texture_block_decoder.sv
// BC1..BC5 texture block decoder.
// Input channel: one compressed 4x4 block per item, in_block_low holds bytes
// 0-7 and in_block_high bytes 8-15, little-endian. Result channel: sixteen
// RGBA texels per block in raster order, with out_texel_index giving each
// texel's position and out_last_texel set on the sixteenth.
// The format register (byte address 0 of the APB port) selects BC1..BC5;
// codes 5..7 decode as BC1. Write it only while the block is idle.
// Throughput: one texel per cycle while blocks are queued and out_stall
// does not hold, set by the texel sequencer that walks the head entry of
// the two-entry block queue. From acceptance a block passes through the
// queue, texel select, the distance stage and the 8-stage square root.
// in_stall rises when the block queue is full. When out_stall holds a texel,
// the whole texel pipeline holds; blocks keep entering until the queue fills.
// Reset empties the queue and pipeline and sets the format to BC1.
module bc_texture_block_decoder #(
  parameter int QueueDepth = bctd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_block_low,
  input  logic [63:0] in_block_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [3:0]  out_texel_index,
  output logic        out_last_texel,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [2:0]     fmt_r;
  logic           en;
  logic           q_valid, pop, t_valid;
  bctd_pkg::blk_t q_head;
  bctd_pkg::txl_t t_txl, o_txl;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {29'd0, fmt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= bctd_pkg::FMT_BC1;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      fmt_r <= pwdata[2:0];
    end
  end

  assign en = !(out_valid && out_stall);

  bctd_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst_n, .fmt(fmt_r), .in_valid, .in_stall,
    .lo(in_block_low), .hi(in_block_high), .q_valid, .q_head, .pop
  );

  bctd_back u_back (
    .clk, .rst_n, .en, .q_valid, .q_head, .pop, .t_valid, .t_txl
  );

  bctd_root u_root (
    .clk, .rst_n, .en, .t_valid, .t_txl, .o_valid(out_valid), .o_txl
  );

  assign out_red         = o_txl.r;
  assign out_green       = o_txl.g;
  assign out_blue        = o_txl.b;
  assign out_alpha       = o_txl.a;
  assign out_texel_index = o_txl.idx;
  assign out_last_texel  = o_txl.last;

endmodule

### sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] r, g, b, a;
    logic [3:0] idx;
    logic       last;
  } texel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_block_low = '0;
  logic [63:0] in_block_high = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_red, out_green, out_blue, out_alpha;
  logic [3:0]  out_texel_index;
  logic        out_last_texel;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  texel_t      texel_q[$];
  logic [2:0]  fmt_model = bctd_pkg::FMT_BC1;
  int          errors = 0;
  longint      cycles = 0;
  bit          quiet = 1'b0;
  bit          took = 1'b0;
  int          hold = 0;

  always #6 clk = ~clk;

  bc_texture_block_decoder DUT (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report(string what, int got, int want);
    errors++;
    if (errors < 40) $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
  endtask

  function automatic logic [7:0] w5(logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] w6(logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  function automatic void colour_pal(logic [63:0] h, bit four, output logic [7:0] pal[4][4]);
    logic [15:0] c0, c1;
    int e0[3], e1[3];
    bit opq;
    c0 = h[15:0];
    c1 = h[31:16];
    opq = four || (c0 > c1);
    e0[0] = int'(w5(c0[15:11])); e0[1] = int'(w6(c0[10:5])); e0[2] = int'(w5(c0[4:0]));
    e1[0] = int'(w5(c1[15:11])); e1[1] = int'(w6(c1[10:5])); e1[2] = int'(w5(c1[4:0]));
    for (int ch = 0; ch < 3; ch++) begin
      pal[0][ch] = 8'(e0[ch]);
      pal[1][ch] = 8'(e1[ch]);
      pal[2][ch] = 8'(opq ? (2 * e0[ch] + e1[ch]) / 3 : (e0[ch] + e1[ch]) / 2);
      pal[3][ch] = 8'(opq ? (e0[ch] + 2 * e1[ch]) / 3 : 0);
    end
    pal[0][3] = 8'd255; pal[1][3] = 8'd255; pal[2][3] = 8'd255;
    pal[3][3] = opq ? 8'd255 : 8'd0;
  endfunction

  function automatic logic [7:0] channel_val(logic [63:0] h, int t);
    int a0, a1, k;
    int tab[8];
    a0 = int'(h[7:0]);
    a1 = int'(h[15:8]);
    tab[0] = a0; tab[1] = a1;
    if (a0 > a1) begin
      for (int i = 1; i <= 6; i++) tab[i + 1] = ((7 - i) * a0 + i * a1) / 7;
    end else begin
      for (int i = 1; i <= 4; i++) tab[i + 1] = ((5 - i) * a0 + i * a1) / 5;
      tab[6] = 0; tab[7] = 255;
    end
    k = int'((h >> (16 + 3 * t)) & 64'd7);
    return 8'(tab[k]);
  endfunction

  function automatic logic [7:0] normal_blue(int r, int g);
    int dx, dy, s, root;
    dx = 2 * r - 255;
    dy = 2 * g - 255;
    s = 65025 - dx * dx - dy * dy;
    root = 0;
    if (s > 0) begin
      while ((root + 1) * (root + 1) <= s) root++;
    end
    return 8'((root + 255) / 2);
  endfunction

  task automatic decode_block(logic [63:0] lo, logic [63:0] hi);
    logic [7:0] pal[4][4];
    texel_t tx;
    int p;
    case (fmt_model)
      bctd_pkg::FMT_BC2, bctd_pkg::FMT_BC3: colour_pal(hi, 1'b1, pal);
      bctd_pkg::FMT_BC4, bctd_pkg::FMT_BC5: ;
      default: colour_pal(lo, 1'b0, pal);
    endcase
    for (int t = 0; t < 16; t++) begin
      case (fmt_model)
        bctd_pkg::FMT_BC2: begin
          p = int'((hi >> (32 + 2 * t)) & 64'd3);
          tx.r = pal[p][0]; tx.g = pal[p][1]; tx.b = pal[p][2];
          tx.a = 8'(((lo >> (4 * t)) & 64'd15) * 64'd17);
        end
        bctd_pkg::FMT_BC3: begin
          p = int'((hi >> (32 + 2 * t)) & 64'd3);
          tx.r = pal[p][0]; tx.g = pal[p][1]; tx.b = pal[p][2];
          tx.a = channel_val(lo, t);
        end
        bctd_pkg::FMT_BC4: begin
          tx.r = channel_val(lo, t);
          tx.g = tx.r; tx.b = tx.r; tx.a = 8'd255;
        end
        bctd_pkg::FMT_BC5: begin
          tx.r = channel_val(lo, t);
          tx.g = channel_val(hi, t);
          tx.b = normal_blue(int'(tx.r), int'(tx.g));
          tx.a = 8'd255;
        end
        default: begin
          p = int'((lo >> (32 + 2 * t)) & 64'd3);
          tx.r = pal[p][0]; tx.g = pal[p][1]; tx.b = pal[p][2]; tx.a = pal[p][3];
        end
      endcase
      tx.idx = 4'(t);
      tx.last = (t == 15);
      texel_q = {texel_q, tx};
    end
  endtask

  always @(posedge clk) begin
    texel_t e;
    took = rst_n && out_valid && !out_stall;
    if (took) begin
      if (texel_q.size() == 0) begin
        report("unexpected texel", int'(out_texel_index), 0);
      end else begin
        e = texel_q.pop_front();
        if (out_red !== e.r) report("red", int'(out_red), int'(e.r));
        if (out_green !== e.g) report("green", int'(out_green), int'(e.g));
        if (out_blue !== e.b) report("blue", int'(out_blue), int'(e.b));
        if (out_alpha !== e.a) report("alpha", int'(out_alpha), int'(e.a));
        if (out_texel_index !== e.idx) begin
          report("texel_index", int'(out_texel_index), int'(e.idx));
        end
        if (out_last_texel !== e.last) begin
          report("last_texel", int'(out_last_texel), int'(e.last));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (took) hold = quiet ? 0 : int'($urandom_range(17));
    if (hold > 0) begin
      out_stall <= 1'b1;
      hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_block(logic [63:0] lo, logic [63:0] hi, bit gaps = 1'b1);
    int w;
    w = gaps ? int'($urandom_range(17)) : 0;
    if (gaps && $urandom_range(2) == 0) w = 0;
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_block_low <= lo;
    in_block_high <= hi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_block(lo, hi);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (texel_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_format(logic [2:0] f);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {$urandom_range(1) ? 29'h1fffffff : 29'h0, f};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    fmt_model = f;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    logic [2:0] f;
    for (int k = 0; k < 5; k++) begin
      f = 3'(k);
      set_format(f);
      send_block('0, '0);
      send_block('1, '1);
      send_block(64'hAAAA_AAAA_0000_FFFF, 64'h5555_5555_FFFF_0000);
      send_block(64'h1B1B_1B1B_1234_5678, 64'hE4E4_E4E4_8765_4321);
    end
    set_format(3'd7);
    send_block(64'h5555_5555_0000_FFFF, rnd64());
  endtask

  task automatic test_random();
    logic [2:0] f;
    logic [63:0] lo, hi;
    for (int ph = 0; ph < 8; ph++) begin
      f = (ph < 5) ? 3'(ph) : 3'($urandom_range(7));
      set_format(f);
      for (int n = 0; n < 55; n++) begin
        lo = rnd64();
        hi = rnd64();
        if ($urandom_range(3) == 0) begin
          lo[15:0] = lo[31:16];
          hi[7:0] = hi[15:8];
        end
        send_block(lo, hi, (n % 20) < 12);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random();
    quiet = 1'b1;
    drain();
    if (errors == 0 && texel_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/bctd_pkg.sv
rtl/bctd_front.sv
rtl/bctd_back.sv
rtl/bctd_root.sv
rtl/bc_texture_block_decoder.sv
sim/tb.sv
